>>> design/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  localparam int MAX_FRAME_BYTES = 1024;

  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 10;
  localparam int WORD16_W = 16;
  localparam int STATUS_W = 2;

  // Frame position counter; the last byte of a legal frame sits at MAX_FRAME_BYTES - 1.
  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  // Length arithmetic is done one bit wider than the length field.
  localparam int LEN_EXT_W = WORD16_W + 1;

  localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_USER    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_ID_LO   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_ID_HI   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(7);

  localparam logic [LEN_EXT_W-1:0] FRAME_OVERHEAD  = LEN_EXT_W'(8);
  localparam logic [LEN_EXT_W-1:0] PAYLOAD_START   = LEN_EXT_W'(7);
  localparam logic [LEN_EXT_W-1:0] FRAME_LIMIT     = LEN_EXT_W'(MAX_FRAME_BYTES);

  localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [0:0] REG_HEADER  = 1'b0;
  localparam logic [0:0] REG_USER_ID = 1'b1;

  localparam int RESULT_BITS  = BYTE_W + INDEX_W + BYTE_W + WORD16_W + WORD16_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((RESULT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - RESULT_BITS;

  typedef struct packed {
    logic [BYTE_W-1:0] header_value;
    logic [BYTE_W-1:0] user_id_value;
  } sfd_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic [BYTE_W-1:0]   frame_type;
    logic [WORD16_W-1:0] message_id;
    logic [WORD16_W-1:0] payload_length;
    logic [STATUS_W-1:0] status;
    logic                last;
  } sfd_result_t;

endpackage
`default_nettype wire

>>> design/serial_frame_deframer_top.sv
`default_nettype none
// A result is registered and appears on the out channel in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the input is not stalled; the parser state updates once per accepted byte.
// The input is stalled only while a held result is not taken by the sink.
// Reset (rst_n low, synchronous) returns the parser to header hunting, clears the
// running sum and held header fields, and loads header 0xA5 and user id 0x01.
module serial_frame_deframer_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [0:0]                       cfg_addr,
  input  wire logic [sfd_pkg::BYTE_W-1:0]       cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sfd_pkg::BYTE_W-1:0]       in_tdata,   // rx_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // data_byte, byte_index, frame_type, message_id, payload_length, status, zero fill
  output logic [sfd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);
  import sfd_pkg::*;

  sfd_cfg_t    cfg_r;
  logic        in_fire;
  logic        res_valid;
  sfd_result_t res;
  logic        out_valid_r;
  sfd_result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value  <= 8'hA5;
      cfg_r.user_id_value <= 8'h01;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HEADER:  cfg_r.header_value  <= cfg_wdata;
        REG_USER_ID: cfg_r.user_id_value <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  sfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_tdata),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {OUT_PAD_W'(0), out_r.status, out_r.payload_length, out_r.message_id,
                       out_r.frame_type, out_r.byte_index, out_r.data_byte};

  // Payload words never carry a status.
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_r.status == STATUS_GOOD)
    else $error("payload word carries a nonzero status");

  // A payload index always lies inside the declared length.
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> WORD16_W'(out_r.byte_index) < out_r.payload_length)
    else $error("payload index beyond declared length");

  // The too-long status appears only for lengths that overflow the frame limit.
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.status == STATUS_TOO_LONG |->
      out_tlast && (LEN_EXT_W'(out_r.payload_length) + FRAME_OVERHEAD) > FRAME_LIMIT)
    else $error("too-long status on a legal length");

  // Every end word, with a checksum verdict or a too-long status, has zero data and index.
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_r.data_byte == '0 && out_r.byte_index == '0)
    else $error("end word carries payload data");

endmodule
`default_nettype wire

>>> design/sfd_parser.sv
`default_nettype none
module sfd_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       byte_fire,
  input  wire logic [sfd_pkg::BYTE_W-1:0] rx_byte,
  input  wire sfd_pkg::sfd_cfg_t          cfg,
  output logic                            res_valid,
  output sfd_pkg::sfd_result_t            res
);
  import sfd_pkg::*;

  logic [POS_W-1:0]    pos_r,  pos_nxt;
  logic [BYTE_W-1:0]   sum_r,  sum_nxt;
  logic [BYTE_W-1:0]   type_r, type_nxt;
  logic [WORD16_W-1:0] len_r,  len_nxt;
  logic [WORD16_W-1:0] id_r,   id_nxt;

  logic [BYTE_W-1:0]    sum_add;
  logic [LEN_EXT_W-1:0] pos_ext;
  logic [LEN_EXT_W-1:0] payload_end;
  logic [POS_W-1:0]     pos_off;
  logic                 too_long;

  assign sum_add     = sum_r + rx_byte;
  assign pos_ext     = LEN_EXT_W'(pos_r);
  assign payload_end = LEN_EXT_W'(len_r) + PAYLOAD_START;
  assign pos_off     = pos_r - POS_PAYLOAD;
  assign too_long    = (LEN_EXT_W'(len_r) + FRAME_OVERHEAD) > FRAME_LIMIT;

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    id_nxt    = id_r;
    res_valid = 1'b0;
    res.data_byte      = '0;
    res.byte_index     = '0;
    res.frame_type     = type_r;
    res.message_id     = id_r;
    res.payload_length = len_r;
    res.status         = STATUS_GOOD;
    res.last           = 1'b0;

    case (pos_r)
      POS_HUNT: begin
        if (rx_byte == cfg.header_value) begin
          sum_nxt = rx_byte;
          pos_nxt = POS_USER;
        end
      end
      POS_USER: begin
        // A wrong user id is dropped and not retried as a header.
        if (rx_byte == cfg.user_id_value) begin
          sum_nxt = sum_add;
          pos_nxt = POS_TYPE;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end
      POS_TYPE: begin
        sum_nxt  = sum_add;
        type_nxt = rx_byte;
        pos_nxt  = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        sum_nxt = sum_add;
        len_nxt = {BYTE_W'(0), rx_byte};
        pos_nxt = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        sum_nxt = sum_add;
        len_nxt = {rx_byte, len_r[BYTE_W-1:0]};
        pos_nxt = POS_ID_LO;
      end
      POS_ID_LO: begin
        sum_nxt = sum_add;
        id_nxt  = {BYTE_W'(0), rx_byte};
        pos_nxt = POS_ID_HI;
      end
      POS_ID_HI: begin
        sum_nxt = sum_add;
        id_nxt  = {rx_byte, id_r[BYTE_W-1:0]};
        res.message_id = {rx_byte, id_r[BYTE_W-1:0]};
        if (too_long) begin
          pos_nxt    = POS_HUNT;
          res_valid  = 1'b1;
          res.status = STATUS_TOO_LONG;
          res.last   = 1'b1;
        end else begin
          pos_nxt = POS_PAYLOAD;
        end
      end
      default: begin
        res_valid = 1'b1;
        if (pos_ext < payload_end) begin
          sum_nxt        = sum_add;
          pos_nxt        = pos_r + POS_W'(1);
          res.data_byte  = rx_byte;
          res.byte_index = INDEX_W'(pos_off);
        end else begin
          pos_nxt    = POS_HUNT;
          res.status = (sum_add == '0) ? STATUS_GOOD : STATUS_BAD_SUM;
          res.last   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      sum_r  <= '0;
      type_r <= '0;
      len_r  <= '0;
      id_r   <= '0;
    end else if (byte_fire) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      id_r   <= id_nxt;
    end
  end

endmodule
`default_nettype wire
